// File: src/allocation_range_table_top_defines.svh
// Assertion macros used by the allocation range table top level.
`ifndef ALLOCATION_RANGE_TABLE_TOP_DEFINES_SVH
`define ALLOCATION_RANGE_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checked property, held off while reset is active.
`define ART_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define ART_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ART_ASSERT(lbl, prop, msg)
`define ART_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: src/art_pkg.sv
// Types and codes shared by the allocation range table modules.
package art_pkg;

  localparam int ADDR_W     = 64;
  localparam int LEN_W      = 32;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int CNT_OUT_W  = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  region_size;
  } art_in_t;

  typedef struct packed {
    logic                 hit;
    logic [ADDR_W-1:0]    region_start;
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] entry_count;
  } art_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
  } art_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } art_state_t;

endpackage

// File: src/art_slot_mem.sv
// Region slot storage: one write port and one registered read port.
module art_slot_mem import art_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int IDX_W   = 6
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output art_entry_t       rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  art_entry_t       wr_data
);

  art_entry_t mem_r [ENTRIES];
  art_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/allocation_range_table_top.sv
// Allocation range table top level: control sequencer, valid bits and count.
//
// Holds up to ENTRIES regions (64-bit start, 32-bit length) keyed by start.
// Input channel: a word on in_word is taken at a rising edge where start is
// high and busy is low. Ops are insert (start, length), delete by start and
// query of an address. Op code 3 does nothing and reports the current count.
// Result channel: one word per input word on out_word, shown for exactly one
// cycle with out_valid high. The receiver cannot stall it.
// Scan: the slot memory is read one entry per cycle through its single
// registered read port, with the compare in the cycle after the read. A
// search stops at the first matching entry or scans the whole table (a miss,
// or an insert of a new start); op code 3 skips the scan. busy stays high
// until the result has been registered, so one word is in flight at a time.
// Reset: clears every valid bit and the entry count at once; the slot memory
// needs no clearing pass, as entries are only read under their valid bit.
// A word may be accepted in the same cycle that the previous result is shown.
`include "allocation_range_table_top_defines.svh"

module allocation_range_table_top import art_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  art_in_t  in_word,
  output logic     busy,
  output logic     out_valid,
  output art_out_t out_word
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  art_state_t state_r, state_nxt;

  logic [OP_W-1:0]    op_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [LEN_W-1:0]   size_r;

  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               issued_all_r, issued_all_nxt;
  logic               cmp_vld_r;
  logic [IDX_W-1:0]   cmp_idx_r;

  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   found_idx_r, found_idx_nxt;
  logic [ADDR_W-1:0]  found_start_r, found_start_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  art_out_t           out_r, out_nxt;

  logic               accept;
  logic               mem_rd_en;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wr_idx;
  art_entry_t         mem_wr_data;
  art_entry_t         rd_entry;

  logic               entry_vld;
  logic               key_hit;
  logic               rng_hit;
  logic               cmp_match;
  logic [ADDR_W:0]    diff;

  assign accept = start && (state_r == ST_IDLE);

  art_slot_mem #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_slot_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_idx  (rd_idx_r),
    .rd_data (rd_entry),
    .wr_en   (mem_we),
    .wr_idx  (mem_wr_idx),
    .wr_data (mem_wr_data)
  );

  // The end of a region is never formed; the offset from its start is
  // compared against the length, so a region near the top never wraps.
  always_comb begin
    entry_vld = valid_r[cmp_idx_r];
    diff      = {1'b0, addr_r} - {1'b0, rd_entry.start};
    key_hit   = entry_vld && (rd_entry.start == addr_r);
    rng_hit   = entry_vld && !diff[ADDR_W] && (diff[ADDR_W-1:LEN_W] == '0) &&
                (diff[LEN_W-1:0] < rd_entry.length);
    cmp_match = (op_r == OP_QUERY) ? rng_hit : key_hit;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if ((in_word.op == OP_INSERT) || (in_word.op == OP_DELETE) ||
              (in_word.op == OP_QUERY)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (cmp_vld_r && (cmp_match || (cmp_idx_r == LAST_IDX))) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath control and outputs.
  always_comb begin
    rd_idx_nxt      = rd_idx_r;
    issued_all_nxt  = issued_all_r;
    found_nxt       = found_r;
    found_idx_nxt   = found_idx_r;
    found_start_nxt = found_start_r;
    free_found_nxt  = free_found_r;
    free_idx_nxt    = free_idx_r;
    valid_nxt       = valid_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = 1'b0;
    out_nxt         = out_r;
    mem_rd_en       = 1'b0;
    mem_we          = 1'b0;
    mem_wr_idx      = found_idx_r;
    mem_wr_data     = '{start: addr_r, length: size_r};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rd_idx_nxt     = '0;
          issued_all_nxt = 1'b0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        mem_rd_en = !issued_all_r;
        if (mem_rd_en) begin
          if (rd_idx_r == LAST_IDX) begin
            issued_all_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end
        if (cmp_vld_r) begin
          if (cmp_match) begin
            found_nxt       = 1'b1;
            found_idx_nxt   = cmp_idx_r;
            found_start_nxt = rd_entry.start;
          end
          // Lowest free slot, for an insert of a new start.
          if (!entry_vld && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
        end
      end
      ST_FINISH: begin
        out_valid_nxt        = 1'b1;
        out_nxt.hit          = 1'b0;
        out_nxt.region_start = '0;
        out_nxt.status       = STATUS_OK;
        unique case (op_r)
          OP_INSERT: begin
            if (found_r) begin
              mem_we = 1'b1;
            end else if (free_found_r) begin
              mem_we                = 1'b1;
              mem_wr_idx            = free_idx_r;
              valid_nxt[free_idx_r] = 1'b1;
              cnt_nxt               = cnt_r + 1'b1;
            end else begin
              out_nxt.status = STATUS_FULL;
            end
          end
          OP_DELETE: begin
            if (found_r) begin
              valid_nxt[found_idx_r] = 1'b0;
              cnt_nxt                = cnt_r - 1'b1;
            end else begin
              out_nxt.status = STATUS_NOT_FOUND;
            end
          end
          OP_QUERY: begin
            out_nxt.hit          = found_r;
            out_nxt.region_start = found_r ? found_start_r : '0;
          end
          default: begin
          end
        endcase
        out_nxt.entry_count = CNT_OUT_W'(cnt_nxt);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= mem_rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_word.op;
      addr_r <= in_word.addr;
      size_r <= in_word.region_size;
    end
    rd_idx_r      <= rd_idx_nxt;
    issued_all_r  <= issued_all_nxt;
    cmp_idx_r     <= rd_idx_r;
    found_r       <= found_nxt;
    found_idx_r   <= found_idx_nxt;
    found_start_r <= found_start_nxt;
    free_found_r  <= free_found_nxt;
    free_idx_r    <= free_idx_nxt;
    out_r         <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  `ART_ASSERT(a_strobe_after_finish, out_valid_r |-> $past(state_r == ST_FINISH), "result strobe without a finishing step")
  `ART_ASSERT(a_idle_has_result, ($past(rst_n) && $fell(busy)) |-> out_valid_r, "busy dropped without a result")
  `ART_ASSERT(a_full_means_full, (out_valid_r && (out_r.status == STATUS_FULL)) |-> (cnt_r == CNT_W'(ENTRIES)), "full reported while a slot is free")
  `ART_ASSERT(a_count_matches_valid, $countones(valid_r) == int'(cnt_r), "entry count differs from the valid bits")

endmodule
